/* hdl/assert_macros.svh */
// Assertion macros shared by the number literal parser RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define NLP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NLP_ASSERT(lbl, clk, rst, prop, msg)
`define NLP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* hdl/nlp_pkg.sv */
// Package for the number literal parser: widths, codes, character constants,
// token phases, divider handshake structs and character decode functions.
// No dependencies.
`default_nettype none

package nlp_pkg;

  // Widths
  localparam int ACCUM_BITS     = 63;
  localparam int FRACTION_BITS  = 32;
  localparam int FRAC_PORT_BITS = 32;
  localparam int FRAC_SHIFT     = FRAC_PORT_BITS - FRACTION_BITS;
  localparam int DIV_BITS       = 64;
  localparam int FRAC_CNT_W     = $clog2(FRACTION_BITS);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_PREFIX   = 3'd1,
    ERR_RADIX    = 3'd2,
    ERR_EXACT    = 3'd3,
    ERR_DIGIT    = 3'd4,
    ERR_DOT      = 3'd5,
    ERR_OVERFLOW = 3'd6
  } err_t;

  // Token phases
  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_HASH        = 4'd1,
    PH_GOT_EXACT   = 4'd2,
    PH_GOT_RADIX   = 4'd3,
    PH_NEED_RADIX  = 4'd4,
    PH_NEED_EXACT  = 4'd5,
    PH_PREFIX_DONE = 4'd6,
    PH_BODY_FIRST  = 4'd7,
    PH_BODY        = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    EX_UNSPEC  = 2'd0,
    EX_EXACT   = 2'd1,
    EX_INEXACT = 2'd2
  } exact_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // Divider request and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= CH_UA && c <= CH_UZ) ? c + CASE_GAP : c;
  endfunction

  function automatic exact_t exact_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    if (lc == CH_E)      exact_of = EX_EXACT;
    else if (lc == CH_I) exact_of = EX_INEXACT;
    else                 exact_of = EX_UNSPEC;
  endfunction

  function automatic logic is_radix_letter(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    is_radix_letter = (lc == CH_B) || (lc == CH_O) || (lc == CH_D) || (lc == CH_X);
  endfunction

  function automatic radix_t radix_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    if (lc == CH_B)      radix_of = RADIX_BIN;
    else if (lc == CH_O) radix_of = RADIX_OCT;
    else if (lc == CH_X) radix_of = RADIX_HEX;
    else                 radix_of = RADIX_DEC;
  endfunction

  function automatic logic [4:0] radix_value(input radix_t r);
    case (r)
      RADIX_BIN: radix_value = 5'd2;
      RADIX_OCT: radix_value = 5'd8;
      RADIX_DEC: radix_value = 5'd10;
      RADIX_HEX: radix_value = 5'd16;
      default:   radix_value = 5'd10;
    endcase
  endfunction

  function automatic logic is_delim(input logic [7:0] c, input logic eoi);
    is_delim = eoi || c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_QUOTE || c == CH_SEMI || c == CH_NUL;
  endfunction

endpackage

`default_nettype wire

/* hdl/nlp_frac_div.sv */
// Iterative fraction divider: one restoring step per cycle, one quotient bit
// per step. Depends on nlp_pkg.
`default_nettype none

module nlp_frac_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire nlp_pkg::div_ctrl_t                 ctrl,
  input  wire logic [nlp_pkg::ACCUM_BITS-1:0]     remainder_init,
  input  wire logic [nlp_pkg::DIV_BITS-1:0]       divisor,
  output nlp_pkg::div_stat_t                      stat,
  output logic [nlp_pkg::FRACTION_BITS-1:0]       quotient
);

  localparam logic [nlp_pkg::FRAC_CNT_W-1:0] LAST_STEP =
    nlp_pkg::FRAC_CNT_W'(nlp_pkg::FRACTION_BITS - 1);

  logic                               running;
  logic                               done;
  logic [nlp_pkg::FRAC_CNT_W-1:0]     count;
  logic [nlp_pkg::DIV_BITS-1:0]       rem;
  logic [nlp_pkg::DIV_BITS-1:0]       dvs;
  logic [nlp_pkg::DIV_BITS:0]         twice;
  logic [nlp_pkg::DIV_BITS:0]         diff;
  logic                               take;

  // Shared compare/subtract: doubled remainder against the divisor
  assign twice = {rem, 1'b0};
  assign diff  = twice - {1'b0, dvs};
  assign take  = (twice >= {1'b0, dvs});

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= nlp_pkg::DIV_BITS'(remainder_init);
      dvs      <= divisor;
      quotient <= '0;
    end else if (running) begin
      rem      <= take ? diff[nlp_pkg::DIV_BITS-1:0] : twice[nlp_pkg::DIV_BITS-1:0];
      quotient <= {quotient[nlp_pkg::FRACTION_BITS-2:0], take};
    end
  end

  assign stat.busy = running | done;
  assign stat.done = done;

endmodule

`default_nettype wire

/* hdl/number_literal_parser_core.sv */
// Number literal parser: one character per cycle while in_stall is low; an
// integer or error result appears in the cycle after the delimiter or
// offending character is taken. A real result waits for the shared divider,
// one restoring step per cycle for 32 fraction bits, input stalled meanwhile.
// Synchronous active-high reset returns the token state to its start and
// empties the output register and the divider.
`default_nettype none
`include "assert_macros.svh"

module number_literal_parser_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          char_code,
  input  wire logic                                end_of_input,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [2:0]                               error_code,
  output logic                                     is_real,
  output logic                                     negative,
  output logic [nlp_pkg::ACCUM_BITS-1:0]           magnitude,
  output logic [nlp_pkg::FRAC_PORT_BITS-1:0]       fraction
);

  localparam int AW = nlp_pkg::ACCUM_BITS;
  localparam int DW = nlp_pkg::DIV_BITS;

  // Token state
  nlp_pkg::phase_t        phase, phase_next;
  nlp_pkg::exact_t        exact_mode, exact_mode_next;
  nlp_pkg::radix_t        radix_code, radix_code_next;
  logic                   sign_negative, sign_negative_next;
  logic                   dot_seen, dot_seen_next;
  logic [AW-1:0]          whole_part, whole_part_next;
  logic [AW-1:0]          digit_acc, digit_acc_next;
  logic [DW-1:0]          frac_div, frac_div_next;

  // Result of the current request
  logic                   in_accept;
  logic                   res_emit;
  nlp_pkg::err_t          res_err;
  logic                   res_real;
  logic                   res_neg;
  logic [AW-1:0]          res_mag;
  logic                   div_start;

  // Character decode
  logic                   delim;
  logic                   hash_char;
  logic                   sign_char;
  logic [7:0]             lc;
  logic                   digit_ok;
  logic [3:0]             digit_val;
  logic                   digit_in_radix;
  logic [AW+4:0]          acc_ext;
  logic [AW+4:0]          acc_prod;
  logic                   acc_ovf;
  logic [DW+3:0]          fd_ext;
  logic [DW+3:0]          fd_prod;
  logic                   fd_ovf;

  nlp_pkg::div_ctrl_t     dctrl;
  nlp_pkg::div_stat_t     dstat;
  logic [nlp_pkg::FRACTION_BITS-1:0] dquo;

  assign in_stall  = dstat.busy | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;

  // Character classes
  assign delim     = nlp_pkg::is_delim(char_code, end_of_input);
  assign hash_char = !end_of_input && char_code == nlp_pkg::CH_HASH;
  assign sign_char = !end_of_input &&
                     (char_code == nlp_pkg::CH_PLUS || char_code == nlp_pkg::CH_MINUS);
  assign lc        = nlp_pkg::to_lower(char_code);

  always_comb begin
    digit_ok  = 1'b1;
    digit_val = '0;
    if (char_code >= nlp_pkg::CH_0 && char_code <= nlp_pkg::CH_9) begin
      digit_val = 4'(char_code - nlp_pkg::CH_0);
    end else if (lc >= nlp_pkg::CH_A && lc <= nlp_pkg::CH_F) begin
      digit_val = 4'(lc - nlp_pkg::CH_A + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign digit_in_radix = {1'b0, digit_val} < nlp_pkg::radix_value(radix_code);

  // Accumulator and divisor times radix, by shift and add; overflow in top bits
  assign acc_ext = (AW + 5)'(digit_acc);
  assign fd_ext  = (DW + 4)'(frac_div);

  always_comb begin
    case (radix_code)
      nlp_pkg::RADIX_BIN: begin
        acc_prod = (acc_ext << 1) + (AW + 5)'(digit_val);
        fd_prod  = fd_ext << 1;
      end
      nlp_pkg::RADIX_OCT: begin
        acc_prod = (acc_ext << 3) + (AW + 5)'(digit_val);
        fd_prod  = fd_ext << 3;
      end
      nlp_pkg::RADIX_HEX: begin
        acc_prod = (acc_ext << 4) + (AW + 5)'(digit_val);
        fd_prod  = fd_ext << 4;
      end
      default: begin
        acc_prod = (acc_ext << 3) + (acc_ext << 1) + (AW + 5)'(digit_val);
        fd_prod  = (fd_ext << 3) + (fd_ext << 1);
      end
    endcase
  end

  assign acc_ovf = |acc_prod[AW+4:AW];
  assign fd_ovf  = |fd_prod[DW+3:DW];

  // Token sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= nlp_pkg::PH_START;
      exact_mode    <= nlp_pkg::EX_UNSPEC;
      radix_code    <= nlp_pkg::RADIX_DEC;
      sign_negative <= 1'b0;
      dot_seen      <= 1'b0;
      whole_part    <= '0;
      digit_acc     <= '0;
      frac_div      <= '0;
    end else begin
      phase         <= phase_next;
      exact_mode    <= exact_mode_next;
      radix_code    <= radix_code_next;
      sign_negative <= sign_negative_next;
      dot_seen      <= dot_seen_next;
      whole_part    <= whole_part_next;
      digit_acc     <= digit_acc_next;
      frac_div      <= frac_div_next;
    end
  end

  always_comb begin
    logic num_start;
    logic body;
    logic first;
    logic tok_clear;

    phase_next         = phase;
    exact_mode_next    = exact_mode;
    radix_code_next    = radix_code;
    sign_negative_next = sign_negative;
    dot_seen_next      = dot_seen;
    whole_part_next    = whole_part;
    digit_acc_next     = digit_acc;
    frac_div_next      = frac_div;
    res_emit           = 1'b0;
    res_err            = nlp_pkg::ERR_NONE;
    res_real           = 1'b0;
    res_neg            = 1'b0;
    res_mag            = '0;
    div_start          = 1'b0;
    num_start          = 1'b0;
    body               = 1'b0;
    first              = 1'b0;
    tok_clear          = 1'b0;

    if (in_accept) begin
      // prefix handling
      case (phase)
        nlp_pkg::PH_START: begin
          if (hash_char) phase_next = nlp_pkg::PH_HASH;
          else           num_start  = 1'b1;
        end
        nlp_pkg::PH_HASH: begin
          if (!end_of_input && nlp_pkg::exact_of(char_code) != nlp_pkg::EX_UNSPEC) begin
            exact_mode_next = nlp_pkg::exact_of(char_code);
            phase_next      = nlp_pkg::PH_GOT_EXACT;
          end else if (!end_of_input && nlp_pkg::is_radix_letter(char_code)) begin
            radix_code_next = nlp_pkg::radix_of(char_code);
            phase_next      = nlp_pkg::PH_GOT_RADIX;
          end else begin
            res_emit  = 1'b1;
            res_err   = nlp_pkg::ERR_PREFIX;
            tok_clear = 1'b1;
          end
        end
        nlp_pkg::PH_GOT_EXACT: begin
          if (hash_char) phase_next = nlp_pkg::PH_NEED_RADIX;
          else           num_start  = 1'b1;
        end
        nlp_pkg::PH_GOT_RADIX: begin
          if (hash_char) phase_next = nlp_pkg::PH_NEED_EXACT;
          else           num_start  = 1'b1;
        end
        nlp_pkg::PH_NEED_RADIX: begin
          if (!end_of_input && nlp_pkg::is_radix_letter(char_code)) begin
            radix_code_next = nlp_pkg::radix_of(char_code);
            phase_next      = nlp_pkg::PH_PREFIX_DONE;
          end else begin
            res_emit  = 1'b1;
            res_err   = nlp_pkg::ERR_RADIX;
            tok_clear = 1'b1;
          end
        end
        nlp_pkg::PH_NEED_EXACT: begin
          if (!end_of_input && nlp_pkg::exact_of(char_code) != nlp_pkg::EX_UNSPEC) begin
            exact_mode_next = nlp_pkg::exact_of(char_code);
            phase_next      = nlp_pkg::PH_PREFIX_DONE;
          end else begin
            res_emit  = 1'b1;
            res_err   = nlp_pkg::ERR_EXACT;
            tok_clear = 1'b1;
          end
        end
        nlp_pkg::PH_BODY_FIRST: begin
          body  = 1'b1;
          first = 1'b1;
        end
        nlp_pkg::PH_BODY: begin
          body = 1'b1;
        end
        default: begin
          num_start = 1'b1;
        end
      endcase

      // optional sign
      if (num_start) begin
        if (sign_char) begin
          sign_negative_next = (char_code == nlp_pkg::CH_MINUS);
          phase_next         = nlp_pkg::PH_BODY_FIRST;
        end else begin
          body  = 1'b1;
          first = 1'b1;
        end
      end

      // number body
      if (body) begin
        if (delim) begin
          tok_clear = 1'b1;
          if (first) begin
            res_emit = 1'b1;
            res_err  = nlp_pkg::ERR_DIGIT;
          end else if (dot_seen) begin
            div_start = 1'b1;
          end else begin
            res_emit = 1'b1;
            res_real = (exact_mode == nlp_pkg::EX_INEXACT);
            res_neg  = sign_negative;
            res_mag  = digit_acc;
          end
        end else if (char_code == nlp_pkg::CH_DOT) begin
          if (dot_seen) begin
            res_emit  = 1'b1;
            res_err   = nlp_pkg::ERR_DOT;
            tok_clear = 1'b1;
          end else begin
            dot_seen_next   = 1'b1;
            whole_part_next = digit_acc;
            digit_acc_next  = '0;
            frac_div_next   = DW'(1);
            phase_next      = nlp_pkg::PH_BODY;
          end
        end else if (!digit_ok || !digit_in_radix) begin
          res_emit  = 1'b1;
          res_err   = nlp_pkg::ERR_DIGIT;
          tok_clear = 1'b1;
        end else if (acc_ovf || (dot_seen && fd_ovf)) begin
          res_emit  = 1'b1;
          res_err   = nlp_pkg::ERR_OVERFLOW;
          tok_clear = 1'b1;
        end else begin
          digit_acc_next = acc_prod[AW-1:0];
          if (dot_seen) frac_div_next = fd_prod[DW-1:0];
          phase_next = nlp_pkg::PH_BODY;
        end
      end

      // back to the start of a token after every result
      if (tok_clear) begin
        phase_next         = nlp_pkg::PH_START;
        exact_mode_next    = nlp_pkg::EX_UNSPEC;
        radix_code_next    = nlp_pkg::RADIX_DEC;
        sign_negative_next = 1'b0;
        dot_seen_next      = 1'b0;
        whole_part_next    = '0;
        digit_acc_next     = '0;
        frac_div_next      = '0;
      end
    end
  end

  // Fraction divider; the fraction digits are always below their divisor
  assign dctrl.start = div_start;

  nlp_frac_div u_frac_div (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (dctrl),
    .remainder_init (digit_acc),
    .divisor        (frac_div),
    .stat           (dstat),
    .quotient       (dquo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_emit || dstat.done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      error_code <= res_err;
      is_real    <= res_real;
      negative   <= res_neg;
      magnitude  <= res_mag;
      fraction   <= '0;
    end else if (div_start) begin
      error_code <= nlp_pkg::ERR_NONE;
      is_real    <= 1'b1;
      negative   <= sign_negative;
      magnitude  <= whole_part;
    end else if (dstat.done) begin
      fraction <= nlp_pkg::FRAC_PORT_BITS'(dquo) << nlp_pkg::FRAC_SHIFT;
    end
  end

  // Checks
  `NLP_ASSERT(a_start_idle, clk, rst, div_start |-> !dstat.busy, "divider started while busy")
  `NLP_ASSERT(a_done_free, clk, rst, dstat.done |-> !out_valid, "divider done over a pending result")
  `NLP_ASSERT(a_done_shows, clk, rst, dstat.done |=> out_valid, "real result not presented")
  `NLP_ASSERT(a_err_clean, clk, rst, (out_valid && error_code != nlp_pkg::ERR_NONE) |-> (!is_real && !negative && magnitude == '0 && fraction == '0), "error request carries a value")

endmodule

`default_nettype wire

/* tb/number_literal_parser_core_tb.sv */
// Self-checking testbench for number_literal_parser_core: a directed table of
// token characters with their results, then random tokens checked against a local lexer.
// Depends on nlp_pkg and the core RTL only.
`timescale 1ns / 100ps

module number_literal_parser_core_tb;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_CHARS = 1250;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [71:0] ACCUM_LIMIT = (72'd1 << nlp_pkg::ACCUM_BITS) - 72'd1;

  typedef struct packed {
    nlp_pkg::err_t                      code;
    logic                               inexact;
    logic                               neg;
    logic [nlp_pkg::ACCUM_BITS-1:0]     mag;
    logic [nlp_pkg::FRAC_PORT_BITS-1:0] frac;
  } lit_result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    logic        typed;
    lit_result_t want;
  } stim_row_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic [7:0]                         char_code;
  logic                               end_of_input;
  logic                               out_valid;
  logic                               out_stall;
  logic [2:0]                         error_code;
  logic                               is_real;
  logic                               negative;
  logic [nlp_pkg::ACCUM_BITS-1:0]     magnitude;
  logic [nlp_pkg::FRAC_PORT_BITS-1:0] fraction;

  number_literal_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .error_code   (error_code),
    .is_real      (is_real),
    .negative     (negative),
    .magnitude    (magnitude),
    .fraction     (fraction)
  );

  // Lexer state mirrored in the testbench
  nlp_pkg::phase_t                tok_phase;
  nlp_pkg::exact_t                tok_exact;
  nlp_pkg::radix_t                tok_radix;
  logic                           tok_neg;
  logic                           tok_dot;
  logic [nlp_pkg::ACCUM_BITS-1:0] int_part;
  logic [nlp_pkg::ACCUM_BITS-1:0] digits;
  logic [nlp_pkg::DIV_BITS-1:0]   frac_div;

  lit_result_t expected_literals[$];
  stim_row_t   directed[$];
  lit_result_t want_res;

  int  mismatches;
  int  sent;
  int  tokens;
  int  ints_seen;
  int  reals_seen;
  int  errors_seen;
  int  cycles;
  bit  steady;
  bit  held;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer
  function automatic void clear_token();
    tok_phase = nlp_pkg::PH_START;
    tok_exact = nlp_pkg::EX_UNSPEC;
    tok_radix = nlp_pkg::RADIX_DEC;
    tok_neg   = 1'b0;
    tok_dot   = 1'b0;
    int_part  = '0;
    digits    = '0;
    frac_div  = '0;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= nlp_pkg::CH_UA && c <= nlp_pkg::CH_UZ) ? {c[7:6], 1'b1, c[4:0]} : c;
  endfunction

  function automatic bit ends_token(input logic [7:0] c, input logic e);
    case (c)
      nlp_pkg::CH_SPACE, nlp_pkg::CH_TAB, nlp_pkg::CH_NL, nlp_pkg::CH_LPAREN,
      nlp_pkg::CH_RPAREN, nlp_pkg::CH_QUOTE, nlp_pkg::CH_SEMI, nlp_pkg::CH_NUL: return 1'b1;
      default: return e;
    endcase
  endfunction

  function automatic nlp_pkg::exact_t exactness_of(input logic [7:0] c, input logic e);
    if (e) return nlp_pkg::EX_UNSPEC;
    case (fold_case(c))
      nlp_pkg::CH_E: return nlp_pkg::EX_EXACT;
      nlp_pkg::CH_I: return nlp_pkg::EX_INEXACT;
      default:       return nlp_pkg::EX_UNSPEC;
    endcase
  endfunction

  function automatic bit radix_letter(input logic [7:0] c, input logic e,
                                      output nlp_pkg::radix_t r);
    r = nlp_pkg::RADIX_DEC;
    if (e) return 1'b0;
    case (fold_case(c))
      nlp_pkg::CH_B: r = nlp_pkg::RADIX_BIN;
      nlp_pkg::CH_O: r = nlp_pkg::RADIX_OCT;
      nlp_pkg::CH_D: r = nlp_pkg::RADIX_DEC;
      nlp_pkg::CH_X: r = nlp_pkg::RADIX_HEX;
      default:       return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic lit_result_t token_error(input nlp_pkg::err_t code);
    lit_result_t r;
    r = '0;
    r.code = code;
    clear_token();
    return r;
  endfunction

  // Value at the delimiter; fraction is floor(rem * 2^FRACTION_BITS / divisor)
  function automatic lit_result_t token_value();
    lit_result_t  r;
    logic [63:0]  rem;
    logic [127:0] quot;
    r = '0;
    r.code    = nlp_pkg::ERR_NONE;
    r.inexact = tok_dot || (tok_exact == nlp_pkg::EX_INEXACT);
    r.neg     = tok_neg;
    r.mag     = tok_dot ? int_part : digits;
    if (tok_dot && frac_div != '0) begin
      rem  = 64'(digits) % frac_div;
      quot = (128'(rem) << nlp_pkg::FRACTION_BITS) / 128'(frac_div);
      r.frac = nlp_pkg::FRAC_PORT_BITS'(quot << nlp_pkg::FRAC_SHIFT);
    end
    clear_token();
    return r;
  endfunction

  function automatic bit body_step(input logic [7:0] c, input logic e, input bit first,
                                   output lit_result_t res);
    logic [7:0]  lc;
    logic [4:0]  v;
    logic [4:0]  base;
    logic [71:0] wide;
    res = '0;
    case (tok_radix)
      nlp_pkg::RADIX_BIN: base = 5'd2;
      nlp_pkg::RADIX_OCT: base = 5'd8;
      nlp_pkg::RADIX_HEX: base = 5'd16;
      default:            base = 5'd10;
    endcase
    if (ends_token(c, e)) begin
      res = first ? token_error(nlp_pkg::ERR_DIGIT) : token_value();
      return 1'b1;
    end
    if (c == nlp_pkg::CH_DOT) begin
      if (tok_dot) begin
        res = token_error(nlp_pkg::ERR_DOT);
        return 1'b1;
      end
      tok_dot   = 1'b1;
      int_part  = digits;
      digits    = '0;
      frac_div  = 64'd1;
      tok_phase = nlp_pkg::PH_BODY;
      return 1'b0;
    end
    lc = fold_case(c);
    if (c >= nlp_pkg::CH_0 && c <= nlp_pkg::CH_9) v = 5'(c - nlp_pkg::CH_0);
    else if (lc >= nlp_pkg::CH_A && lc <= nlp_pkg::CH_F) v = 5'(lc - nlp_pkg::CH_A + 8'd10);
    else begin
      res = token_error(nlp_pkg::ERR_DIGIT);
      return 1'b1;
    end
    if (v >= base) begin
      res = token_error(nlp_pkg::ERR_DIGIT);
      return 1'b1;
    end
    // accumulator must stay within ACCUM_BITS, divisor within 64 bits
    wide = 72'(digits) * base + 72'(v);
    if (wide > ACCUM_LIMIT) begin
      res = token_error(nlp_pkg::ERR_OVERFLOW);
      return 1'b1;
    end
    digits = wide[nlp_pkg::ACCUM_BITS-1:0];
    if (tok_dot) begin
      wide = 72'(frac_div) * base;
      if (wide[71:64] != '0) begin
        res = token_error(nlp_pkg::ERR_OVERFLOW);
        return 1'b1;
      end
      frac_div = wide[63:0];
    end
    tok_phase = nlp_pkg::PH_BODY;
    return 1'b0;
  endfunction

  function automatic bit number_start(input logic [7:0] c, input logic e,
                                      output lit_result_t res);
    res = '0;
    if (!e && (c == nlp_pkg::CH_PLUS || c == nlp_pkg::CH_MINUS)) begin
      tok_neg   = (c == nlp_pkg::CH_MINUS);
      tok_phase = nlp_pkg::PH_BODY_FIRST;
      return 1'b0;
    end
    return body_step(c, e, 1'b1, res);
  endfunction

  // One character through the lexer; returns 1 when it produces a result
  function automatic bit lex_char(input logic [7:0] c, input logic e, output lit_result_t res);
    nlp_pkg::exact_t ex;
    nlp_pkg::radix_t rx;
    res = '0;
    ex  = exactness_of(c, e);
    case (tok_phase)
      nlp_pkg::PH_START: begin
        if (!e && c == nlp_pkg::CH_HASH) begin
          tok_phase = nlp_pkg::PH_HASH;
          return 1'b0;
        end
        return number_start(c, e, res);
      end
      nlp_pkg::PH_HASH: begin
        if (ex != nlp_pkg::EX_UNSPEC) begin
          tok_exact = ex;
          tok_phase = nlp_pkg::PH_GOT_EXACT;
          return 1'b0;
        end
        if (radix_letter(c, e, rx)) begin
          tok_radix = rx;
          tok_phase = nlp_pkg::PH_GOT_RADIX;
          return 1'b0;
        end
        res = token_error(nlp_pkg::ERR_PREFIX);
        return 1'b1;
      end
      nlp_pkg::PH_GOT_EXACT: begin
        if (!e && c == nlp_pkg::CH_HASH) begin
          tok_phase = nlp_pkg::PH_NEED_RADIX;
          return 1'b0;
        end
        return number_start(c, e, res);
      end
      nlp_pkg::PH_GOT_RADIX: begin
        if (!e && c == nlp_pkg::CH_HASH) begin
          tok_phase = nlp_pkg::PH_NEED_EXACT;
          return 1'b0;
        end
        return number_start(c, e, res);
      end
      nlp_pkg::PH_NEED_RADIX: begin
        if (!radix_letter(c, e, rx)) begin
          res = token_error(nlp_pkg::ERR_RADIX);
          return 1'b1;
        end
        tok_radix = rx;
        tok_phase = nlp_pkg::PH_PREFIX_DONE;
        return 1'b0;
      end
      nlp_pkg::PH_NEED_EXACT: begin
        if (ex == nlp_pkg::EX_UNSPEC) begin
          res = token_error(nlp_pkg::ERR_EXACT);
          return 1'b1;
        end
        tok_exact = ex;
        tok_phase = nlp_pkg::PH_PREFIX_DONE;
        return 1'b0;
      end
      nlp_pkg::PH_PREFIX_DONE: return number_start(c, e, res);
      nlp_pkg::PH_BODY_FIRST:  return body_step(c, e, 1'b1, res);
      nlp_pkg::PH_BODY:        return body_step(c, e, 1'b0, res);
      default: begin
        clear_token();
        return number_start(c, e, res);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic stim_row_t char_row(input logic [7:0] c);
    stim_row_t r;
    r = '0;
    r.ch = c;
    return r;
  endfunction

  function automatic stim_row_t result_row(input logic [7:0] c, input logic e,
                                           input nlp_pkg::err_t code,
                                           input logic inexact, input logic neg,
                                           input logic [nlp_pkg::ACCUM_BITS-1:0] mag,
                                           input logic [nlp_pkg::FRAC_PORT_BITS-1:0] frac);
    stim_row_t r;
    r.ch           = c;
    r.eoi          = e;
    r.typed        = 1'b1;
    r.want.code    = code;
    r.want.inexact = inexact;
    r.want.neg     = neg;
    r.want.mag     = mag;
    r.want.frac    = frac;
    return r;
  endfunction

  // Offer one character, wait for it to be taken, then log what it should produce
  task automatic push_char(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                           input lit_result_t typed_res = '0);
    lit_result_t res;
    bit          got;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    got = lex_char(c, e, res);
    if (typed) expected_literals.push_back(typed_res);
    else if (got) expected_literals.push_back(res);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'(nlp_pkg::CH_0 + v);
    return 8'(($urandom_range(0, 1) ? nlp_pkg::CH_A : nlp_pkg::CH_UA) + (v - 10));
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? 8'(c - nlp_pkg::CASE_GAP) : c;
  endfunction

  task automatic push_delim();
    if ($urandom_range(0, 7) == 0) push_char(8'($urandom_range(0, 255)), 1'b1);
    else begin
      case ($urandom_range(0, 7))
        0: push_char(nlp_pkg::CH_SPACE, 1'b0);
        1: push_char(nlp_pkg::CH_TAB, 1'b0);
        2: push_char(nlp_pkg::CH_NL, 1'b0);
        3: push_char(nlp_pkg::CH_LPAREN, 1'b0);
        4: push_char(nlp_pkg::CH_RPAREN, 1'b0);
        5: push_char(nlp_pkg::CH_QUOTE, 1'b0);
        6: push_char(nlp_pkg::CH_SEMI, 1'b0);
        default: push_char(nlp_pkg::CH_NUL, 1'b0);
      endcase
    end
  endtask

  // One random token: mostly well formed, some broken, some pure noise
  task automatic push_token();
    int unsigned base;
    int unsigned prefix;
    int unsigned ndig;
    int          dot_at;
    logic [7:0]  radix_ch;
    tokens++;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 6))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      return;
    end
    case ($urandom_range(0, 3))
      0: begin base = 2;  radix_ch = nlp_pkg::CH_B; end
      1: begin base = 8;  radix_ch = nlp_pkg::CH_O; end
      2: begin base = 10; radix_ch = nlp_pkg::CH_D; end
      default: begin base = 16; radix_ch = nlp_pkg::CH_X; end
    endcase
    prefix = $urandom_range(0, 15);
    if (prefix < 4) base = 10;
    // exactness prefix first
    if (prefix == 4 || prefix == 5 || prefix == 8 || prefix == 14) begin
      push_char(nlp_pkg::CH_HASH, 1'b0);
      push_char(any_case($urandom_range(0, 1) ? nlp_pkg::CH_E : nlp_pkg::CH_I), 1'b0);
      if (prefix == 4) base = 10;
    end
    // radix prefix
    if (prefix >= 5 && prefix <= 9) begin
      push_char(nlp_pkg::CH_HASH, 1'b0);
      push_char(any_case(radix_ch), 1'b0);
    end else if (prefix >= 10 && prefix <= 12) begin
      base = 10;
    end
    // exactness after radix
    if (prefix == 9 || prefix == 15) begin
      if (prefix == 15) begin
        push_char(nlp_pkg::CH_HASH, 1'b0);
        push_char(any_case(radix_ch), 1'b0);
      end
      push_char(nlp_pkg::CH_HASH, 1'b0);
      push_char(prefix == 15 ? 8'($urandom_range(0, 255))
                             : any_case($urandom_range(0, 1) ? nlp_pkg::CH_E : nlp_pkg::CH_I),
                1'b0);
    end
    // broken prefixes: a bare hash, or an incomplete second prefix
    if (prefix == 13) begin
      push_char(nlp_pkg::CH_HASH, 1'b0);
      push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
    if (prefix == 14) begin
      push_char(nlp_pkg::CH_HASH, 1'b0);
      push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
    // sign, digits with an optional dot, delimiter
    case ($urandom_range(0, 2))
      1: push_char(nlp_pkg::CH_PLUS, 1'b0);
      2: push_char(nlp_pkg::CH_MINUS, 1'b0);
      default: ;
    endcase
    ndig   = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 66) : $urandom_range(0, 7);
    dot_at = $urandom_range(0, 1) ? int'($urandom_range(0, ndig)) : -1;
    for (int i = 0; i <= int'(ndig); i++) begin
      if (i == dot_at) push_char(nlp_pkg::CH_DOT, 1'b0);
      if (i < int'(ndig)) begin
        if ($urandom_range(0, 59) == 0) push_char(8'($urandom_range(0, 255)), 1'b0);
        else push_char(digit_char($urandom_range(0, base - 1)), 1'b0);
      end
    end
    if ($urandom_range(0, 24) == 0) push_char(nlp_pkg::CH_DOT, 1'b0);
    push_delim();
  endtask

  // ---------------------------------------------------------------- receive side
  always @(posedge clk) begin
    if (steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Each result taken is compared with the oldest pending literal
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_literals.size() == 0) begin
        $display("%0t: result with none expected: error_code %0d magnitude %0h fraction %0h",
                 $time, error_code, magnitude, fraction);
        mismatches++;
      end else begin
        want_res = expected_literals.pop_front();
        check_field("error_code", want_res.code, error_code);
        check_field("is_real", want_res.inexact, is_real);
        check_field("negative", want_res.neg, negative);
        check_field("magnitude", want_res.mag, magnitude);
        check_field("fraction", want_res.frac, fraction);
        if (want_res.code != nlp_pkg::ERR_NONE) errors_seen++;
        else if (want_res.inexact) reals_seen++;
        else ints_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_literals.size());
      $display("number_literal_parser_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    char_code    <= 8'd0;
    end_of_input <= 1'b0;
    mismatches   = 0;
    sent         = 0;
    tokens       = 0;
    ints_seen    = 0;
    reals_seen   = 0;
    errors_seen  = 0;
    steady       = 1'b0;
    held         = 1'b0;
    clear_token();

    // empty token, bad prefix, incomplete second prefixes, lone dot,
    // exact with dot, sign inside the body, top byte, second dot
    directed.push_back(result_row(nlp_pkg::CH_NUL, 1'b0, nlp_pkg::ERR_DIGIT,
                                  1'b0, 1'b0, '0, '0));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(result_row("Z", 1'b0, nlp_pkg::ERR_PREFIX, 1'b0, 1'b0, '0, '0));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(char_row(nlp_pkg::CH_E));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(result_row("q", 1'b0, nlp_pkg::ERR_RADIX, 1'b0, 1'b0, '0, '0));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(char_row("X"));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(result_row("k", 1'b0, nlp_pkg::ERR_EXACT, 1'b0, 1'b0, '0, '0));
    directed.push_back(char_row(nlp_pkg::CH_DOT));
    directed.push_back(result_row(nlp_pkg::CH_SPACE, 1'b0, nlp_pkg::ERR_NONE,
                                  1'b1, 1'b0, '0, '0));
    directed.push_back(char_row(nlp_pkg::CH_HASH));
    directed.push_back(char_row("E"));
    directed.push_back(char_row(nlp_pkg::CH_MINUS));
    directed.push_back(char_row("1"));
    directed.push_back(char_row(nlp_pkg::CH_DOT));
    directed.push_back(char_row("8"));
    directed.push_back(result_row(8'hFF, 1'b1, nlp_pkg::ERR_NONE, 1'b1, 1'b1, 63'd1,
                                  32'hCCCC_CCCC));
    directed.push_back(char_row(nlp_pkg::CH_PLUS));
    directed.push_back(result_row(nlp_pkg::CH_PLUS, 1'b0, nlp_pkg::ERR_DIGIT,
                                  1'b0, 1'b0, '0, '0));
    directed.push_back(result_row(8'hFF, 1'b0, nlp_pkg::ERR_DIGIT, 1'b0, 1'b0, '0, '0));
    directed.push_back(char_row("1"));
    directed.push_back(char_row(nlp_pkg::CH_DOT));
    directed.push_back(result_row(nlp_pkg::CH_DOT, 1'b0, nlp_pkg::ERR_DOT,
                                  1'b0, 1'b0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      push_char(directed[i].ch, directed[i].eoi, directed[i].typed, directed[i].want);

    while (sent < RANDOM_CHARS + directed.size()) begin
      steady = (sent >= 600 && sent < 800);
      // hold off once until everything outstanding has been delivered
      if (!held && sent >= 400) begin
        held = 1'b1;
        in_valid <= 1'b0;
        while (expected_literals.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      push_token();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_literals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in %0d random tokens after the directed table", sent, tokens);
    $display("results checked: %0d integers, %0d reals, %0d errors",
             ints_seen, reals_seen, errors_seen);
    if (mismatches == 0) $display("number_literal_parser_core: match");
    else $display("number_literal_parser_core: mismatch");
    $finish;
  end

endmodule
